/* rtl/core/bpf_pkg.sv */
// Package for the blacklist packet filter: command codes, table kinds and
// the queue word passed from the parser to the match engine. No dependencies.
`default_nettype none
package bpf_pkg;

    // command codes carried in tuser
    localparam logic [2:0] CMD_BYTE = 3'd0;
    localparam logic [2:0] CMD_MAC  = 3'd1;
    localparam logic [2:0] CMD_IPV4 = 3'd2;
    localparam logic [2:0] CMD_IPV6 = 3'd3;
    localparam logic [2:0] CMD_UDP  = 3'd4;
    localparam logic [2:0] CMD_TCP  = 3'd5;

    // reason codes
    localparam logic [2:0] RSN_NONE  = 3'd0;
    localparam logic [2:0] RSN_TRUNC = 3'd1;
    localparam logic [2:0] RSN_MAC   = 3'd2;
    localparam logic [2:0] RSN_IPV4  = 3'd3;
    localparam logic [2:0] RSN_IPV6  = 3'd4;
    localparam logic [2:0] RSN_UDP   = 3'd5;
    localparam logic [2:0] RSN_TCP   = 3'd6;

    localparam logic [10:0] POS_MAX = 11'd2047;
    localparam logic [15:0] ETH_VLAN = 16'h8100;
    localparam logic [15:0] ETH_QINQ = 16'h88A8;
    localparam logic [15:0] ETH_IPV4 = 16'h0800;
    localparam logic [15:0] ETH_IPV6 = 16'h86DD;
    localparam logic [15:0] PROTO_UDP = 16'd17;
    localparam logic [15:0] PROTO_TCP = 16'd6;

    // queue between parser and match engine
    localparam int QDEPTH = 4;

    typedef enum logic [2:0] {
        TBL_MAC,
        TBL_IPV4,
        TBL_IPV6,
        TBL_UDP,
        TBL_TCP
    } tbl_t;

    // one queued word: a table write, a header check and/or a packet end
    typedef struct packed {
        tbl_t        tbl;
        logic        is_wr;
        logic        is_chk;
        logic        is_end;
        logic [2:0]  reason;     // parser-side verdict reason at packet end
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic [7:0]  plen;
        logic [3:0]  idx;
        logic        valid;
        logic        dir;
    } qword_t;

endpackage
`default_nettype wire

/* rtl/core/bpf_fifo.sv */
// Short queue of parser words between front and back.
// Depends on bpf_pkg.
`default_nettype none
module bpf_fifo
    import bpf_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   push,
    input  qword_t      push_word,
    output logic        full,
    input  wire logic   pop,
    output logic        empty,
    output qword_t      head
);
    localparam int AW = $clog2(QDEPTH);

    qword_t           mem [QDEPTH];
    logic [AW-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]      count_reg;

    assign full  = (count_reg == (AW+1)'(QDEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_word;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/core/bpf_parser.sv */
// Front end: walks packet bytes through the header stages and queues
// table writes, header checks and packet ends. Depends on bpf_pkg.
`default_nettype none
module bpf_parser
    import bpf_pkg::*;
#(
    parameter int VLAN_DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [2:0]  cmd,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    input  wire logic [63:0] key_high,
    input  wire logic [63:0] key_low,
    input  wire logic [7:0]  prefix_length,
    input  wire logic [3:0]  entry_index,
    input  wire logic        entry_valid,
    input  wire logic        port_direction,
    output logic             push,
    output qword_t           push_word
);
    typedef enum logic [2:0] {
        ST_ETH, ST_VLAN, ST_IPV4, ST_IPV6, ST_UDP, ST_TCP, ST_DONE
    } stage_t;

    stage_t      stage_reg, stage_next;
    logic [10:0] pos_reg, pos_next;
    logic [10:0] hstart_reg, hstart_next;
    logic [10:0] l4start_reg, l4start_next;
    logic [15:0] nproto_reg, nproto_next;
    logic [1:0]  tags_reg, tags_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic [47:0] smac_reg, smac_next;
    logic [63:0] siph_reg, siph_next;
    logic [63:0] sipl_reg, sipl_next;
    logic [15:0] sport_reg, sport_next;
    logic [15:0] dport_reg, dport_next;
    logic [2:0]  freason_reg, freason_next;
    logic [10:0] rel;
    logic [15:0] nproto_full;

    function automatic stage_t after_l2(input logic [15:0] np, input logic [1:0] tags);
        if ((np == ETH_VLAN || np == ETH_QINQ) && 32'(tags) < VLAN_DEPTH)
            return ST_VLAN;
        else if (np == ETH_IPV4)
            return ST_IPV4;
        else if (np == ETH_IPV6)
            return ST_IPV6;
        else
            return ST_DONE;
    endfunction

    function automatic stage_t after_l3(input logic [15:0] np);
        if (np == PROTO_UDP)
            return ST_UDP;
        else if (np == PROTO_TCP)
            return ST_TCP;
        else
            return ST_DONE;
    endfunction

    assign rel         = pos_reg - hstart_reg;
    assign nproto_full = {nproto_reg[15:8], data_byte};

    // byte parsing and queue word build
    always_comb
    begin
        stage_next   = stage_reg;
        pos_next     = pos_reg;
        hstart_next  = hstart_reg;
        l4start_next = l4start_reg;
        nproto_next  = nproto_reg;
        tags_next    = tags_reg;
        ihl_next     = ihl_reg;
        smac_next    = smac_reg;
        siph_next    = siph_reg;
        sipl_next    = sipl_reg;
        sport_next   = sport_reg;
        dport_next   = dport_reg;
        freason_next = freason_reg;
        push         = 1'b0;
        push_word          = '0;
        push_word.tbl      = TBL_MAC;
        push_word.key_high = key_high;
        push_word.key_low  = key_low;
        push_word.plen     = prefix_length;
        push_word.idx      = entry_index;
        push_word.valid    = entry_valid;
        push_word.dir      = port_direction;

        if (accept && cmd == CMD_BYTE)
        begin
            if (stage_reg != ST_DONE && pos_reg >= hstart_reg)
            begin
                unique case (stage_reg)
                    ST_ETH:
                    begin
                        if (rel >= 11'd6 && rel <= 11'd11)
                            smac_next = {smac_reg[39:0], data_byte};
                        else if (rel == 11'd12)
                            nproto_next = {data_byte, 8'h00};
                        else if (rel == 11'd13)
                        begin
                            nproto_next = nproto_full;
                            push = 1'b1;
                            push_word.is_chk  = 1'b1;
                            push_word.tbl     = TBL_MAC;
                            push_word.key_low = {16'h0, smac_reg};
                            hstart_next = 11'd14;
                            stage_next  = after_l2(nproto_full, tags_reg);
                        end
                    end
                    ST_VLAN:
                    begin
                        if (rel == 11'd2)
                            nproto_next = {data_byte, 8'h00};
                        else if (rel == 11'd3)
                        begin
                            nproto_next = nproto_full;
                            tags_next   = tags_reg + 2'd1;
                            hstart_next = hstart_reg + 11'd4;
                            stage_next  = after_l2(nproto_full, tags_reg + 2'd1);
                        end
                    end
                    ST_IPV4:
                    begin
                        if (rel == 11'd0)
                        begin
                            ihl_next     = data_byte[3:0];
                            l4start_next = hstart_reg + {5'd0, data_byte[3:0], 2'b00};
                        end
                        else if (rel == 11'd9)
                            nproto_next = {8'h00, data_byte};
                        else if (rel >= 11'd12 && rel <= 11'd15)
                            sipl_next = {32'h0, sipl_reg[23:0], data_byte};
                        else if (rel == 11'd19)
                        begin
                            push = 1'b1;
                            push_word.is_chk  = 1'b1;
                            push_word.tbl     = TBL_IPV4;
                            push_word.key_low = {32'h0, sipl_reg[31:0]};
                            if (ihl_reg < 4'd5)
                            begin
                                freason_next = RSN_TRUNC;
                                stage_next   = ST_DONE;
                            end
                            else
                            begin
                                hstart_next = l4start_reg;
                                stage_next  = after_l3(nproto_reg);
                            end
                        end
                    end
                    ST_IPV6:
                    begin
                        if (rel == 11'd6)
                            nproto_next = {8'h00, data_byte};
                        else if (rel >= 11'd8 && rel <= 11'd15)
                            siph_next = {siph_reg[55:0], data_byte};
                        else if (rel >= 11'd16 && rel <= 11'd23)
                            sipl_next = {sipl_reg[55:0], data_byte};
                        else if (rel == 11'd39)
                        begin
                            push = 1'b1;
                            push_word.is_chk   = 1'b1;
                            push_word.tbl      = TBL_IPV6;
                            push_word.key_high = siph_reg;
                            push_word.key_low  = sipl_reg;
                            l4start_next = hstart_reg + 11'd40;
                            hstart_next  = hstart_reg + 11'd40;
                            stage_next   = after_l3(nproto_reg);
                        end
                    end
                    ST_UDP, ST_TCP:
                    begin
                        if (rel <= 11'd1)
                            sport_next = {sport_reg[7:0], data_byte};
                        else if (rel <= 11'd3)
                            dport_next = {dport_reg[7:0], data_byte};
                        if ((stage_reg == ST_UDP && rel == 11'd7) ||
                            (stage_reg == ST_TCP && rel == 11'd19))
                        begin
                            push = 1'b1;
                            push_word.is_chk  = 1'b1;
                            push_word.tbl     = (stage_reg == ST_UDP) ? TBL_UDP : TBL_TCP;
                            push_word.key_low = {32'h0, dport_next, sport_next};
                            stage_next = ST_DONE;
                        end
                    end
                    default:
                    begin
                        stage_next = ST_DONE;
                    end
                endcase
            end

            if (pos_reg < POS_MAX)
                pos_next = pos_reg + 11'd1;

            // packet end: queue the parser's verdict and clear packet state
            if (last_byte)
            begin
                push = 1'b1;
                push_word.is_end = 1'b1;
                if (freason_next != RSN_NONE)
                    push_word.reason = freason_next;
                else if (stage_next != ST_DONE)
                    push_word.reason = RSN_TRUNC;
                else
                    push_word.reason = RSN_NONE;
                stage_next   = ST_ETH;
                pos_next     = '0;
                hstart_next  = '0;
                l4start_next = '0;
                nproto_next  = '0;
                tags_next    = '0;
                ihl_next     = '0;
                smac_next    = '0;
                siph_next    = '0;
                sipl_next    = '0;
                sport_next   = '0;
                dport_next   = '0;
                freason_next = RSN_NONE;
            end
        end
        else if (accept && cmd >= CMD_MAC && cmd <= CMD_TCP)
        begin
            push = 1'b1;
            push_word.is_wr = 1'b1;
            unique case (cmd)
                CMD_MAC:  push_word.tbl = TBL_MAC;
                CMD_IPV4: push_word.tbl = TBL_IPV4;
                CMD_IPV6: push_word.tbl = TBL_IPV6;
                CMD_UDP:  push_word.tbl = TBL_UDP;
                default:  push_word.tbl = TBL_TCP;
            endcase
        end
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg   <= ST_ETH;
            pos_reg     <= '0;
            hstart_reg  <= '0;
            l4start_reg <= '0;
            nproto_reg  <= '0;
            tags_reg    <= '0;
            ihl_reg     <= '0;
            smac_reg    <= '0;
            siph_reg    <= '0;
            sipl_reg    <= '0;
            sport_reg   <= '0;
            dport_reg   <= '0;
            freason_reg <= RSN_NONE;
        end
        else
        begin
            stage_reg   <= stage_next;
            pos_reg     <= pos_next;
            hstart_reg  <= hstart_next;
            l4start_reg <= l4start_next;
            nproto_reg  <= nproto_next;
            tags_reg    <= tags_next;
            ihl_reg     <= ihl_next;
            smac_reg    <= smac_next;
            siph_reg    <= siph_next;
            sipl_reg    <= sipl_next;
            sport_reg   <= sport_next;
            dport_reg   <= dport_next;
            freason_reg <= freason_next;
        end
    end
endmodule
`default_nettype wire

/* rtl/core/bpf_match.sv */
// Back end: holds the blacklist tables, compares queued header checks in
// parallel and forms the packet verdict word. Depends on bpf_pkg.
`default_nettype none
module bpf_match
    import bpf_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire logic   empty,
    input  qword_t      head,
    output logic        pop,
    output logic        out_valid,
    input  wire logic   out_ready,
    output logic        out_verdict,
    output logic [2:0]  out_reason
);
    logic [47:0]  mac_key   [TABLE_DEPTH];
    logic [31:0]  v4_key    [TABLE_DEPTH];
    logic [5:0]   v4_len    [TABLE_DEPTH];
    logic [127:0] v6_key    [TABLE_DEPTH];
    logic [7:0]   v6_len    [TABLE_DEPTH];
    logic [16:0]  udp_ent   [TABLE_DEPTH];
    logic [16:0]  tcp_ent   [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] mac_vld_reg, v4_vld_reg, v6_vld_reg, udp_vld_reg, tcp_vld_reg;

    logic         hit_seen_reg;
    logic [2:0]   hit_reason_reg;
    logic         out_valid_reg;
    logic [2:0]   out_reason_reg;

    logic         hit;
    logic [2:0]   hit_code;
    logic [2:0]   final_reason;
    logic [5:0]   v4_plen;
    logic [7:0]   v6_plen;

    assign pop         = !empty && (!head.is_end || !out_valid_reg || out_ready);
    assign out_valid   = out_valid_reg;
    assign out_reason  = out_reason_reg;
    assign out_verdict = (out_reason_reg != RSN_NONE);

    // clamp prefix lengths on write
    assign v4_plen = (head.plen > 8'd32) ? 6'd32 : head.plen[5:0];
    assign v6_plen = (head.plen > 8'd128) ? 8'd128 : head.plen;

    // parallel compare against all valid entries
    always_comb
    begin
        hit = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            unique case (head.tbl)
                TBL_MAC:
                    if (mac_vld_reg[i] && mac_key[i] == head.key_low[47:0])
                        hit = 1'b1;
                TBL_IPV4:
                    if (v4_vld_reg[i] && (((v4_key[i] ^ head.key_low[31:0]) &
                        (32'hFFFF_FFFF << (6'd32 - v4_len[i]))) == 32'h0))
                        hit = 1'b1;
                TBL_IPV6:
                    if (v6_vld_reg[i] && (((v6_key[i] ^ {head.key_high, head.key_low}) &
                        ({128{1'b1}} << (8'd128 - v6_len[i]))) == 128'h0))
                        hit = 1'b1;
                TBL_UDP:
                    if (udp_vld_reg[i] && udp_ent[i][15:0] ==
                        (udp_ent[i][16] ? head.key_low[31:16] : head.key_low[15:0]))
                        hit = 1'b1;
                default:
                    if (tcp_vld_reg[i] && tcp_ent[i][15:0] ==
                        (tcp_ent[i][16] ? head.key_low[31:16] : head.key_low[15:0]))
                        hit = 1'b1;
            endcase
        end
    end

    always_comb
    begin
        unique case (head.tbl)
            TBL_MAC:  hit_code = RSN_MAC;
            TBL_IPV4: hit_code = RSN_IPV4;
            TBL_IPV6: hit_code = RSN_IPV6;
            TBL_UDP:  hit_code = RSN_UDP;
            default:  hit_code = RSN_TCP;
        endcase
    end

    // first hit of the packet wins over the parser's reason
    always_comb
    begin
        priority if (hit_seen_reg)
            final_reason = hit_reason_reg;
        else if (head.is_chk && hit)
            final_reason = hit_code;
        else
            final_reason = head.reason;
    end

    // table payloads
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (pop && head.is_wr && 32'(head.idx) == i)
            begin
                unique case (head.tbl)
                    TBL_MAC:  mac_key[i] <= head.key_low[47:0];
                    TBL_IPV4:
                    begin
                        v4_key[i] <= head.key_low[31:0];
                        v4_len[i] <= v4_plen;
                    end
                    TBL_IPV6:
                    begin
                        v6_key[i] <= {head.key_high, head.key_low};
                        v6_len[i] <= v6_plen;
                    end
                    TBL_UDP:  udp_ent[i] <= {head.dir, head.key_low[15:0]};
                    default:  tcp_ent[i] <= {head.dir, head.key_low[15:0]};
                endcase
            end
        end
    end

    // valid bits, hit tracking and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_vld_reg    <= '0;
            v4_vld_reg     <= '0;
            v6_vld_reg     <= '0;
            udp_vld_reg    <= '0;
            tcp_vld_reg    <= '0;
            hit_seen_reg   <= 1'b0;
            hit_reason_reg <= RSN_NONE;
            out_valid_reg  <= 1'b0;
            out_reason_reg <= RSN_NONE;
        end
        else
        begin
            // output word: load on a packet end, clear once taken
            if (pop && head.is_end)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (pop)
            begin
                if (head.is_wr)
                begin
                    for (int i = 0; i < TABLE_DEPTH; i++)
                    begin
                        if (32'(head.idx) == i)
                        begin
                            unique case (head.tbl)
                                TBL_MAC:  mac_vld_reg[i] <= head.valid;
                                TBL_IPV4: v4_vld_reg[i]  <= head.valid;
                                TBL_IPV6: v6_vld_reg[i]  <= head.valid;
                                TBL_UDP:  udp_vld_reg[i] <= head.valid;
                                default:  tcp_vld_reg[i] <= head.valid;
                            endcase
                        end
                    end
                end
                if (head.is_end)
                begin
                    out_reason_reg <= final_reason;
                    hit_seen_reg   <= 1'b0;
                end
                else if (head.is_chk && hit && !hit_seen_reg)
                begin
                    hit_seen_reg   <= 1'b1;
                    hit_reason_reg <= hit_code;
                end
            end
        end
    end
endmodule
`default_nettype wire

/* rtl/core/l2_l3_l4_blacklist_packet_filter_core.sv */
// Top level of the blacklist packet filter: parser front end, word queue
// and match back end. Depends on bpf_pkg, bpf_parser, bpf_fifo, bpf_match.
//
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      tdata, tuser = cmd, tlast = last_byte
// m_axis    out  m_axis_tvalid/tready      tdata = verdict, reason
//
// One word per cycle: the parser takes a word each clock while the queue has
// room; the match engine retires one queued word per clock unless a stalled
// output holds it, using a combinational parallel compare over all table
// slots. With the queue empty, the last byte's end word is queued, then popped
// into the registered verdict. Reset clears parser state, the queue and every
// table valid bit at once. A stalled output holds the queue at a packet-end
// word; words behind it wait, and once the queue is full the input stalls too.
`default_nettype none
module l2_l3_l4_blacklist_packet_filter_core
    import bpf_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int VLAN_DEPTH  = 2
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [7:0] data_byte, [71:8] key_high, [135:72] key_low, [143:136] prefix_length,
    // [147:144] entry_index, [148] entry_valid, [149] port_direction, [151:150] zero
    input  wire logic [151:0] s_axis_tdata,
    // [2:0] cmd
    input  wire logic [2:0]   s_axis_tuser,
    input  wire logic         s_axis_tlast,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [0] verdict, [3:1] reason, [7:4] zero
    output logic [7:0]        m_axis_tdata
);
    logic    accept, push, full, pop, empty;
    qword_t  push_word, head;
    logic    verdict;
    logic [2:0] reason;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && !full;
    assign m_axis_tdata  = {4'h0, reason, verdict};

    bpf_parser #(.VLAN_DEPTH(VLAN_DEPTH)) u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .cmd            (s_axis_tuser),
        .data_byte      (s_axis_tdata[7:0]),
        .last_byte      (s_axis_tlast),
        .key_high       (s_axis_tdata[71:8]),
        .key_low        (s_axis_tdata[135:72]),
        .prefix_length  (s_axis_tdata[143:136]),
        .entry_index    (s_axis_tdata[147:144]),
        .entry_valid    (s_axis_tdata[148]),
        .port_direction (s_axis_tdata[149]),
        .push           (push),
        .push_word      (push_word)
    );

    bpf_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    bpf_match #(.TABLE_DEPTH(TABLE_DEPTH)) u_match (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_verdict (verdict),
        .out_reason  (reason)
    );
endmodule
`default_nettype wire
